// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define VTM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define VTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VTM_ASSERT_NOW(label, clk, rst, ante, cons)
`define VTM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/vtm_pkg.sv
// ---------------------------------------------------------------------------
// vtm_pkg
// Types and constants shared by the virtual timer multiplexer.
// ---------------------------------------------------------------------------
package vtm_pkg;

   localparam int SLOTS_DEF = 16;

   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int TICKS_W = 32;
   localparam int NOW_W   = 16;
   localparam int WRAPS_W = 20;
   localparam int CMP_W   = 16;
   localparam int ENTRY_W = WRAPS_W + CMP_W;

   // ticks split: low part goes into the compare value, upper part counts wraps
   localparam int FRAC_W  = 14;
   localparam int QSHIFT  = 2;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRAP  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_HIT   = 2'd3;

   localparam logic RES_FIRED = 1'b0;
   localparam logic RES_SCHED = 1'b1;

   localparam logic [WRAPS_W-1:0] WRAPS_MIN = {1'b1, {(WRAPS_W-1){1'b0}}};

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [TICKS_W-1:0] ticks;
      logic [NOW_W-1:0]   now;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [SLOT_W-1:0]  fired_slot;
      logic               armed;
      logic [NOW_W-1:0]   delay;
      logic               last;
   } rsp_type;

   // verdict on one slot entry
   typedef struct packed {
      logic               dec_en;
      logic [WRAPS_W-1:0] new_wraps;
      logic               hit_zero;
      logic               expired;
      logic               better;
   } eval_type;

endpackage

// File: rtl/vtm_ram.sv
// ---------------------------------------------------------------------------
// vtm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vtm_slot_eval.sv
// ---------------------------------------------------------------------------
// vtm_slot_eval
// Judges one slot entry: wrap decrement, expiry and earliest-compare test.
// ---------------------------------------------------------------------------
module vtm_slot_eval (
   input  logic                        running,
   input  logic [vtm_pkg::WRAPS_W-1:0] wraps,
   input  logic [vtm_pkg::CMP_W-1:0]   cmp,
   input  logic [vtm_pkg::NOW_W-1:0]   now,
   input  logic                        best_vld,
   input  logic [vtm_pkg::CMP_W-1:0]   best_cmp,
   output vtm_pkg::eval_type           verdict
);

   logic wraps_zero;
   logic wraps_neg;
   logic due_now;

   assign wraps_zero = (wraps == '0);
   assign wraps_neg  = wraps[vtm_pkg::WRAPS_W-1];
   assign due_now    = (cmp <= now);

   always_comb begin
      verdict.dec_en = running;
      // saturate at the most negative count
      verdict.new_wraps = (wraps == vtm_pkg::WRAPS_MIN) ? wraps
                        : wraps - vtm_pkg::WRAPS_W'(1);
      verdict.hit_zero = running && (verdict.new_wraps == '0);
      verdict.expired  = running && (wraps_neg || (wraps_zero && due_now));
      verdict.better   = running && wraps_zero && !due_now
                         && (!best_vld || (cmp < best_cmp));
   end

endmodule

// File: rtl/virtual_timer_multiplexer_unit.sv
// ---------------------------------------------------------------------------
// virtual_timer_multiplexer_unit
// Virtual timers multiplexed onto one free-running 16-bit counter.
// ---------------------------------------------------------------------------
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_data       in         start && !busy
//   response  rsp_strobe, rsp_data        out        strobe, one cycle
//
// Sequence: start/stop do one write, a read sweep over the slot RAM, then
//   one schedule result. Compare hit does the read sweep and the schedule
//   result. A wrap does a decrement sweep over the slot RAM, followed by a
//   read sweep and the schedule result if a slot reached zero wraps.
// Reset: synchronous, clears the sequencer and all running flags; RAM
//   contents only take effect for running slots, so need no clearing.
// Stalls: none, the receiver takes each result in the cycle it is shown.
//
module virtual_timer_multiplexer_unit #(
   parameter int SLOTS = vtm_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vtm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output vtm_pkg::rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WRITE = 5'b00010,
      ST_WRAP  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   vtm_pkg::req_type              item_ff, item_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          eval_vld_ff, eval_vld_in;
   logic [AW-1:0]                 eval_idx_ff, eval_idx_in;
   logic [SLOTS-1:0]              running_ff, running_in;
   logic                          best_vld_ff, best_vld_in;
   logic [vtm_pkg::CMP_W-1:0]     best_cmp_ff, best_cmp_in;
   logic                          any_zero_ff, any_zero_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   vtm_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // slot RAM ports
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [vtm_pkg::ENTRY_W-1:0]   wr_data;
   logic                          rd_en;
   logic [vtm_pkg::ENTRY_W-1:0]   rd_data;
   logic [vtm_pkg::WRAPS_W-1:0]   rd_wraps;
   logic [vtm_pkg::CMP_W-1:0]     rd_cmp;

   vtm_pkg::eval_type             verdict;

   // start conversion
   logic [vtm_pkg::NOW_W:0]       conv_q;
   logic [vtm_pkg::WRAPS_W-1:0]   conv_wraps;
   logic [AW-1:0]                 slot_idx;
   logic                          slot_ok;
   logic                          sweep;
   logic                          sweep_done;

   assign rd_wraps = rd_data[vtm_pkg::ENTRY_W-1:vtm_pkg::CMP_W];
   assign rd_cmp   = rd_data[vtm_pkg::CMP_W-1:0];

   vtm_ram #(
      .WIDTH (vtm_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   vtm_slot_eval u_eval (
      .running  (running_ff[eval_idx_ff]),
      .wraps    (rd_wraps),
      .cmp      (rd_cmp),
      .now      (item_ff.now),
      .best_vld (best_vld_ff),
      .best_cmp (best_cmp_ff),
      .verdict  (verdict)
   );

   // quarter-ticks of the low part plus now; carry rolls into the wraps
   assign conv_q = {1'b0, item_ff.ticks[vtm_pkg::FRAC_W-1:0], {vtm_pkg::QSHIFT{1'b0}}}
                 + {1'b0, item_ff.now};
   assign conv_wraps = vtm_pkg::WRAPS_W'(item_ff.ticks[vtm_pkg::TICKS_W-1:vtm_pkg::FRAC_W])
                     + vtm_pkg::WRAPS_W'(conv_q[vtm_pkg::NOW_W]);

   assign slot_idx = AW'(item_ff.slot);
   assign slot_ok  = (int'(item_ff.slot) < SLOTS);

   assign sweep      = (state_ff == ST_WRAP) || (state_ff == ST_SCAN);
   assign sweep_done = eval_vld_ff && (eval_idx_ff == AW'(SLOTS - 1));

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = '0;
      eval_vld_in   = 1'b0;
      eval_idx_in   = cnt_ff[AW-1:0];
      running_in    = running_ff;
      best_vld_in   = best_vld_ff;
      best_cmp_in   = best_cmp_ff;
      any_zero_in   = any_zero_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_data       = {verdict.new_wraps, rd_cmp};
      rd_en         = 1'b0;

      // read one slot a cycle; its verdict follows in the next cycle
      if (sweep) begin
         if (cnt_ff < CW'(SLOTS)) begin
            rd_en       = 1'b1;
            eval_vld_in = 1'b1;
            cnt_in      = cnt_ff + CW'(1);
         end else begin
            cnt_in = cnt_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = req_data;
               best_vld_in = 1'b0;
               any_zero_in = 1'b0;
               if (req_data.kind == vtm_pkg::KIND_WRAP) begin
                  state_in = ST_WRAP;
               end else if (req_data.kind == vtm_pkg::KIND_HIT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (slot_ok) begin
               if (item_ff.kind == vtm_pkg::KIND_START) begin
                  wr_en                = 1'b1;
                  wr_addr              = slot_idx;
                  wr_data              = {conv_wraps, conv_q[vtm_pkg::CMP_W-1:0]};
                  running_in[slot_idx] = 1'b1;
               end else begin
                  running_in[slot_idx] = 1'b0;
               end
            end
            state_in = ST_SCAN;
         end
         ST_WRAP: begin
            // write-back trails the read by one slot, never the same entry
            if (eval_vld_ff && verdict.dec_en) begin
               wr_en = 1'b1;
            end
            if (eval_vld_ff && verdict.hit_zero) begin
               any_zero_in = 1'b1;
            end
            if (sweep_done) begin
               cnt_in = '0;
               if (any_zero_ff || verdict.hit_zero) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (eval_vld_ff) begin
               if (verdict.expired) begin
                  running_in[eval_idx_ff] = 1'b0;
                  rsp_strobe_in           = 1'b1;
                  rsp_data_in.result_kind = vtm_pkg::RES_FIRED;
                  rsp_data_in.fired_slot  = vtm_pkg::SLOT_W'(eval_idx_ff);
                  rsp_data_in.armed       = 1'b0;
                  rsp_data_in.delay       = '0;
                  rsp_data_in.last        = 1'b0;
               end
               // expired and schedulable are disjoint, so one pass does both
               if (verdict.better) begin
                  best_vld_in = 1'b1;
                  best_cmp_in = rd_cmp;
               end
            end
            if (sweep_done) begin
               cnt_in   = '0;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in.result_kind = vtm_pkg::RES_SCHED;
            rsp_data_in.fired_slot  = '0;
            rsp_data_in.armed       = best_vld_ff;
            rsp_data_in.delay       = best_vld_ff ? best_cmp_ff - item_ff.now : '0;
            rsp_data_in.last        = 1'b1;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         eval_vld_ff   <= 1'b0;
         running_ff    <= '0;
         best_vld_ff   <= 1'b0;
         any_zero_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         eval_vld_ff   <= eval_vld_in;
         running_ff    <= running_in;
         best_vld_ff   <= best_vld_in;
         any_zero_ff   <= any_zero_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      eval_idx_ff <= eval_idx_in;
      best_cmp_ff <= best_cmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // an accepted item always occupies the sequencer
   `VTM_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // the closing result of an item is never directly followed by another
   `VTM_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe_ff && rsp_data_ff.last,
      !rsp_strobe_ff)
   // a fired result never closes an item; the schedule result follows it
   `VTM_ASSERT_NOW(a_fired_not_last, clock, reset,
      rsp_strobe_ff && (rsp_data_ff.result_kind == vtm_pkg::RES_FIRED), !rsp_data_ff.last)
   // no verdict arrives outside a sweep, so never while the sequencer is idle
   `VTM_ASSERT_NOW(a_eval_in_sweep, clock, reset, eval_vld_ff, sweep)

endmodule
